[design/gsc_pkg.sv]
// ---------------------------------------------------------------------------
// gsc_pkg: shared types and constants for the greedy set cover unit
// Field widths, action and status codes, register indexes, FSM states and
// the control bundle sent from the sequencer to the chain of set cells.
// ---------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

    localparam int MAX_SETS_DEF  = 16;
    localparam int MAX_ELEMS_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int SET_W    = 4;
    localparam int ELEM_W   = 4;
    localparam int STATUS_W = 2;
    localparam int GAIN_W   = 5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0]  CFG_NUM_SETS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_NUM_ELEMS = 1'd1;
    localparam logic [CFG_DATA_W-1:0] NUM_SETS_RST  = 5'd16;
    localparam logic [CFG_DATA_W-1:0] NUM_ELEMS_RST = 5'd16;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_PICK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUBLISH
    } gsc_state_t;

    typedef struct packed {
        logic              clear;
        logic              load;
        logic [SET_W-1:0]  load_set;
        logic [ELEM_W-1:0] load_elem;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[design/gsc_req_if.sv]
// ---------------------------------------------------------------------------
// gsc_req_if: request channel of the greedy set cover unit
// Valid/ready channel carrying action, set index and element.
// ---------------------------------------------------------------------------
`default_nettype none

interface gsc_req_if;
    logic                         valid;
    logic                         ready;
    logic [gsc_pkg::ACTION_W-1:0] action;
    logic [gsc_pkg::SET_W-1:0]    set_index;
    logic [gsc_pkg::ELEM_W-1:0]   element;

    modport source (output valid, action, set_index, element, input ready);
    modport sink   (input valid, action, set_index, element, output ready);
endinterface

`default_nettype wire

[design/gsc_rsp_if.sv]
// ---------------------------------------------------------------------------
// gsc_rsp_if: result channel of the greedy set cover unit
// Valid/ready channel carrying status, picked set, gain and last flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface gsc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [gsc_pkg::STATUS_W-1:0] status;
    logic [gsc_pkg::SET_W-1:0]    picked_set;
    logic [gsc_pkg::GAIN_W-1:0]   gain;
    logic                         last;

    modport source (output valid, status, picked_set, gain, last, input ready);
    modport sink   (input valid, status, picked_set, gain, last, output ready);
endinterface

`default_nettype wire

[design/gsc_cell.sv]
// ---------------------------------------------------------------------------
// gsc_cell: one candidate set of the greedy set cover chain
// Holds one set mask. During a scan it compares its own uncovered count with
// the best-so-far record from its left neighbor and passes the winner right.
// ---------------------------------------------------------------------------
`default_nettype none

module gsc_cell #(
    parameter int MAX_SETS  = gsc_pkg::MAX_SETS_DEF,
    parameter int MAX_ELEMS = gsc_pkg::MAX_ELEMS_DEF,
    parameter int CELL_IDX  = 0,
    localparam int GW = $clog2(MAX_ELEMS + 1),
    localparam int IW = $clog2(MAX_SETS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gsc_pkg::cell_ctrl_t ctrl,
    input  logic                active,
    input  logic [MAX_ELEMS-1:0] um,
    input  logic [MAX_ELEMS-1:0] covered,
    input  logic                in_valid,
    input  logic [GW-1:0]       in_gain,
    input  logic [IW-1:0]       in_idx,
    input  logic [MAX_ELEMS-1:0] in_mask,
    output logic                out_valid,
    output logic [GW-1:0]       out_gain,
    output logic [IW-1:0]       out_idx,
    output logic [MAX_ELEMS-1:0] out_mask
);

    localparam logic [MAX_ELEMS-1:0] ONE = {{(MAX_ELEMS-1){1'b0}}, 1'b1};

    logic [MAX_ELEMS-1:0] mask_reg, mask_next;
    logic                 valid_reg;
    logic [GW-1:0]        gain_reg;
    logic [IW-1:0]        idx_reg;
    logic [MAX_ELEMS-1:0] bmask_reg;
    logic [GW-1:0]        own_gain;
    logic [MAX_ELEMS-1:0] live;

    function automatic logic [GW-1:0] count_ones(input logic [MAX_ELEMS-1:0] v);
        logic [GW-1:0] c;
        c = '0;
        for (int j = 0; j < MAX_ELEMS; j++)
            c = c + GW'(v[j]);
        return c;
    endfunction

    always_comb
    begin
        mask_next = mask_reg;
        if (ctrl.clear)
            mask_next = '0;
        else if (ctrl.load && (32'(ctrl.load_set) == CELL_IDX))
            mask_next = mask_reg | (ONE << ctrl.load_elem);
    end

    assign live     = mask_reg & um & ~covered;
    assign own_gain = active ? count_ones(live) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= in_valid;
        end
    end

    // strict compare: an earlier set keeps a tie
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            if (own_gain > in_gain)
            begin
                gain_reg  <= own_gain;
                idx_reg   <= IW'(CELL_IDX);
                bmask_reg <= mask_reg & um;
            end
            else
            begin
                gain_reg  <= in_gain;
                idx_reg   <= in_idx;
                bmask_reg <= in_mask;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_gain  = gain_reg;
    assign out_idx   = idx_reg;
    assign out_mask  = bmask_reg;

endmodule

`default_nettype wire

[design/greedy_set_cover_unit.sv]
// ---------------------------------------------------------------------------
// greedy_set_cover_unit: greedy set cover engine on a chain of set cells
// Sequencer, covered mask, configuration and result register around a row
// of gsc_cell instances, one per candidate set.
// ---------------------------------------------------------------------------
//  channel | dir | payload                              | transaction when
//  req     | in  | action, set_index, element           | req.valid & req.ready
//  rsp     | out | status, picked_set, gain, last       | rsp.valid & rsp.ready
//  cfg     | in  | cfg_index, cfg_data                  | cfg_we
//
//  Clear and add are handled when taken in idle. A run repeats rounds: each
//  round launches one record, sends it down the MAX_SETS-cell chain and
//  publishes the winner, until a round finds no gain.
//  Reset clears all set masks, the covered mask and the FSM at once.
//  A stalled rsp holds the sequencer in publish; req is not taken meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module greedy_set_cover_unit #(
    parameter int MAX_SETS  = gsc_pkg::MAX_SETS_DEF,
    parameter int MAX_ELEMS = gsc_pkg::MAX_ELEMS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gsc_req_if.sink                        req,
    gsc_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [gsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int GW = $clog2(MAX_ELEMS + 1);
    localparam int IW = $clog2(MAX_SETS);

    gsc_pkg::gsc_state_t state_reg, state_next;

    logic [gsc_pkg::CFG_DATA_W-1:0] num_sets_reg, num_elems_reg;
    logic [MAX_ELEMS-1:0]           covered_reg, covered_next;
    logic                           inj_reg, inj_next;

    logic                           rsp_valid_reg, rsp_valid_next;
    logic [gsc_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [gsc_pkg::SET_W-1:0]      picked_reg, picked_next;
    logic [gsc_pkg::GAIN_W-1:0]     gain_reg, gain_next;
    logic                           last_reg, last_next;
    logic                           out_load;

    logic                 slot_free, req_fire, add_ok;
    logic [MAX_ELEMS-1:0] um;
    logic [MAX_SETS-1:0]  active;
    gsc_pkg::cell_ctrl_t  ctrl;

    logic                 ch_valid [0:MAX_SETS];
    logic [GW-1:0]        ch_gain  [0:MAX_SETS];
    logic [IW-1:0]        ch_idx   [0:MAX_SETS];
    logic [MAX_ELEMS-1:0] ch_mask  [0:MAX_SETS];

    logic          res_pick;
    logic [GW-1:0] res_gain;

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign res_gain  = ch_gain[MAX_SETS];
    assign res_pick  = (res_gain != '0);

    // universe and set-in-use masks; saturation to the parameter is implicit
    always_comb
    begin
        for (int j = 0; j < MAX_ELEMS; j++)
            um[j] = (32'(num_elems_reg) > j);
        for (int i = 0; i < MAX_SETS; i++)
            active[i] = (32'(num_sets_reg) > i);
    end

    assign add_ok = (32'(req.set_index) < 32'(num_sets_reg)) && (32'(req.set_index) < MAX_SETS)
                 && (32'(req.element) < 32'(num_elems_reg)) && (32'(req.element) < MAX_ELEMS);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sets_reg  <= gsc_pkg::NUM_SETS_RST;
            num_elems_reg <= gsc_pkg::NUM_ELEMS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gsc_pkg::CFG_NUM_SETS:  num_sets_reg  <= cfg_data;
                gsc_pkg::CFG_NUM_ELEMS: num_elems_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gsc_pkg::S_IDLE:
                if (req_fire && req.action == gsc_pkg::ACT_RUN)
                    state_next = gsc_pkg::S_SCAN;
            gsc_pkg::S_SCAN:
                if (ch_valid[MAX_SETS])
                    state_next = gsc_pkg::S_PUBLISH;
            gsc_pkg::S_PUBLISH:
                if (slot_free)
                    state_next = res_pick ? gsc_pkg::S_SCAN : gsc_pkg::S_IDLE;
            default:
                state_next = gsc_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready      = 1'b0;
        inj_next       = 1'b0;
        out_load       = 1'b0;
        status_next    = gsc_pkg::STAT_DONE;
        picked_next    = '0;
        gain_next      = '0;
        last_next      = 1'b1;
        covered_next   = covered_reg;
        ctrl.clear     = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.load_set  = req.set_index;
        ctrl.load_elem = req.element;
        unique case (state_reg)
            gsc_pkg::S_IDLE:
            begin
                req.ready = slot_free;
                if (req_fire)
                begin
                    unique case (req.action)
                        gsc_pkg::ACT_CLEAR:
                        begin
                            ctrl.clear   = 1'b1;
                            covered_next = '0;
                        end
                        gsc_pkg::ACT_ADD:
                        begin
                            ctrl.load = add_ok;
                            if (!add_ok)
                            begin
                                out_load    = 1'b1;
                                status_next = gsc_pkg::STAT_REJECT;
                            end
                        end
                        gsc_pkg::ACT_RUN:
                            inj_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            gsc_pkg::S_SCAN: ;
            gsc_pkg::S_PUBLISH:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (res_pick)
                    begin
                        status_next  = gsc_pkg::STAT_PICK;
                        picked_next  = gsc_pkg::SET_W'(ch_idx[MAX_SETS]);
                        gain_next    = gsc_pkg::GAIN_W'(res_gain);
                        last_next    = 1'b0;
                        covered_next = covered_reg | ch_mask[MAX_SETS];
                        inj_next     = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsc_pkg::S_IDLE;
            covered_reg   <= '0;
            inj_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            covered_reg   <= covered_next;
            inj_reg       <= inj_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_next;
            picked_reg <= picked_next;
            gain_reg   <= gain_next;
            last_reg   <= last_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.picked_set = picked_reg;
    assign rsp.gain       = gain_reg;
    assign rsp.last       = last_reg;

    // chain head: inj_reg is registered together with covered, so a launch sees the updated mask
    assign ch_valid[0] = inj_reg;
    assign ch_gain[0]  = '0;
    assign ch_idx[0]   = '0;
    assign ch_mask[0]  = '0;

    for (genvar i = 0; i < MAX_SETS; i++)
    begin : g_cell
        gsc_cell #(
            .MAX_SETS  (MAX_SETS),
            .MAX_ELEMS (MAX_ELEMS),
            .CELL_IDX  (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .active    (active[i]),
            .um        (um),
            .covered   (covered_reg),
            .in_valid  (ch_valid[i]),
            .in_gain   (ch_gain[i]),
            .in_idx    (ch_idx[i]),
            .in_mask   (ch_mask[i]),
            .out_valid (ch_valid[i+1]),
            .out_gain  (ch_gain[i+1]),
            .out_idx   (ch_idx[i+1]),
            .out_mask  (ch_mask[i+1])
        );
    end

endmodule

`default_nettype wire

[design/gsc_checker.sv]
// ---------------------------------------------------------------------------
// gsc_checker: port-level checks for the greedy set cover unit
// Watches the request and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module gsc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic [gsc_pkg::ACTION_W-1:0] req_action,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic [gsc_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [gsc_pkg::SET_W-1:0]    rsp_picked_set,
    input wire logic [gsc_pkg::GAIN_W-1:0]   rsp_gain,
    input wire logic                         rsp_last
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_picked_set) && $stable(rsp_gain) && $stable(rsp_last))
        else $error("stalled result changed");

    a_pick_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == gsc_pkg::STAT_PICK |-> !rsp_last && rsp_gain != '0)
        else $error("pick result with last set or zero gain");

    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != gsc_pkg::STAT_PICK
            |-> rsp_last && rsp_gain == '0 && rsp_picked_set == '0)
        else $error("done or reject result malformed");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_action == gsc_pkg::ACT_RUN |=> !req_ready)
        else $error("request taken right after a run started");

endmodule

bind greedy_set_cover_unit gsc_checker u_gsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_action     (req.action),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_picked_set (rsp.picked_set),
    .rsp_gain       (rsp.gain),
    .rsp_last       (rsp.last)
);

`default_nettype wire
